@@ rtl/aqi_pkg.sv @@
// ----------------------------------------------------------------------------
// aqi_pkg: shared types and constants of the PM2.5 to AQI unit
// Breakpoint segments, division constants, brackets and the structs
// that carry items between the pipeline sections.
// ----------------------------------------------------------------------------
package aqi_pkg;

  // Field widths.
  localparam int RD_W   = 16;   // PM2.5 reading
  localparam int DIFF_W = 20;   // 10*reading minus lower bound, in tenths
  localparam int NUM_W  = 31;   // dividend 2*num + den
  localparam int RCP_W  = 24;   // reciprocal of the divisor, scaled by 2^32
  localparam int RCP_SH = 32;   // reciprocal scale
  localparam int Q_W    = 19;   // quotient and unsaturated index
  localparam int AQI_W  = 16;
  localparam int CAT_W  = 3;
  localparam int RGB_W  = 24;
  localparam int SEG_W  = 3;

  localparam int SEGMENTS = 6;
  localparam int BRACKETS = 6;

  localparam longint unsigned RCP_ONE = 64'h1_0000_0000;

  // Segment table, concentrations in tenths of a microgram per cubic meter.
  localparam logic [11:0] SEG_LO10 [SEGMENTS] = '{
    12'd0, 12'd155, 12'd405, 12'd655, 12'd1505, 12'd2505
  };
  localparam logic [11:0] SEG_SPAN10 [SEGMENTS] = '{
    12'd154, 12'd249, 12'd249, 12'd849, 12'd999, 12'd2499
  };
  localparam logic [9:0] SEG_ISPAN [SEGMENTS] = '{
    10'd50, 10'd49, 10'd49, 10'd49, 10'd99, 10'd999
  };
  localparam logic [8:0] SEG_BASE [SEGMENTS] = '{
    9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301
  };

  // Divisor 2*span and its truncated reciprocal floor(2^32 / divisor).
  localparam logic [12:0] SEG_DIV [SEGMENTS] = '{
    13'd308, 13'd498, 13'd498, 13'd1698, 13'd1998, 13'd4998
  };
  localparam logic [RCP_W-1:0] SEG_RCP [SEGMENTS] = '{
    RCP_W'(RCP_ONE / 64'd308),  RCP_W'(RCP_ONE / 64'd498),
    RCP_W'(RCP_ONE / 64'd498),  RCP_W'(RCP_ONE / 64'd1698),
    RCP_W'(RCP_ONE / 64'd1998), RCP_W'(RCP_ONE / 64'd4998)
  };

  // Quality brackets: upper index bound and colour.
  localparam logic [9:0] BRK_MAX [BRACKETS] = '{
    10'd50, 10'd100, 10'd150, 10'd200, 10'd300, 10'd999
  };
  localparam logic [RGB_W-1:0] BRK_RGB [BRACKETS] = '{
    24'h00FF00, 24'hFFFF00, 24'hFFA500, 24'hFF0000, 24'h9400D3, 24'h9400D3
  };
  localparam logic [CAT_W-1:0] CAT_HAZARDOUS = 3'd5;

  // Item after segment choice and numerator product.
  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [NUM_W-1:0] dvd;
  } aqi_dvd_t;

  // Item after division.
  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [Q_W-1:0]   quo;
  } aqi_quo_t;

  // Finished result item.
  typedef struct packed {
    logic             saturated;
    logic [RGB_W-1:0] colour;
    logic [CAT_W-1:0] category;
    logic [AQI_W-1:0] aqi_value;
  } aqi_res_t;

endpackage

@@ rtl/aqi_seg.sv @@
// ----------------------------------------------------------------------------
// aqi_seg: segment choice and dividend
// Two stages: pick the breakpoint segment and the offset into it, then
// form the rounding dividend 2*offset*index_span + span.
// ----------------------------------------------------------------------------
module aqi_seg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [aqi_pkg::RD_W-1:0] rd,
  output logic                     out_valid,
  input  logic                     out_ready,
  output aqi_pkg::aqi_dvd_t        out_data
);
  import aqi_pkg::*;

  logic              a_valid;
  logic [SEG_W-1:0]  a_seg;
  logic [DIFF_W-1:0] a_diff;
  logic              a_ready;
  logic              b_valid;
  aqi_dvd_t          b_data;
  logic              b_ready;

  logic [DIFF_W-1:0] r10;
  logic [SEG_W-1:0]  seg_next;
  logic [DIFF_W-1:0] diff_next;
  logic [29:0]       num;
  aqi_dvd_t          b_next;

  // Each stage takes a new item when it is empty or its item moves on.
  assign b_ready   = !b_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid;
  assign out_data  = b_data;

  // Stage A: last segment whose lower bound is not above the reading.
  always_comb begin
    r10 = DIFF_W'({rd, 3'b000}) + DIFF_W'({rd, 1'b0});
    seg_next = '0;
    for (int i = 1; i < SEGMENTS; i++) begin
      if (r10 >= DIFF_W'(SEG_LO10[i])) begin
        seg_next = SEG_W'(i);
      end
    end
    diff_next = r10 - DIFF_W'(SEG_LO10[seg_next]);
  end

  // Stage B: dividend of the rounded quotient.
  always_comb begin
    num        = 30'(a_diff * SEG_ISPAN[a_seg]);
    b_next.seg = a_seg;
    b_next.dvd = NUM_W'({num, 1'b0}) + NUM_W'(SEG_SPAN10[a_seg]);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_seg  <= seg_next;
      a_diff <= diff_next;
    end
    if (b_ready && a_valid) begin
      b_data <= b_next;
    end
  end

endmodule

@@ rtl/aqi_div.sv @@
// ----------------------------------------------------------------------------
// aqi_div: division by the segment's constant divisor
// Stage C multiplies by a truncated reciprocal, which gives the quotient
// or one less. Stage D forms the remainder and corrects by one.
// ----------------------------------------------------------------------------
module aqi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aqi_pkg::aqi_dvd_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aqi_pkg::aqi_quo_t out_data
);
  import aqi_pkg::*;

  logic             c_valid;
  logic             c_ready;
  logic [SEG_W-1:0] c_seg;
  logic [NUM_W-1:0] c_dvd;
  logic [Q_W-1:0]   c_qest;
  logic             d_valid;
  logic             d_ready;
  aqi_quo_t         d_data;

  logic [NUM_W+RCP_W-1:0] rcp_prod;
  logic [Q_W-1:0]         qest_next;
  logic [NUM_W-1:0]       back_prod;
  logic [NUM_W-1:0]       rem;
  logic [NUM_W-1:0]       dvsr;
  aqi_quo_t               d_next;

  assign d_ready   = !d_valid || out_ready;
  assign c_ready   = !c_valid || d_ready;
  assign in_ready  = c_ready;
  assign out_valid = d_valid;
  assign out_data  = d_data;

  // Stage C: quotient estimate from the reciprocal.
  always_comb begin
    rcp_prod  = (NUM_W+RCP_W)'(in_data.dvd) * (NUM_W+RCP_W)'(SEG_RCP[in_data.seg]);
    qest_next = rcp_prod[RCP_SH +: Q_W];
  end

  // Stage D: remainder check, add one when the estimate fell short.
  always_comb begin
    dvsr       = NUM_W'(SEG_DIV[c_seg]);
    back_prod  = NUM_W'(c_qest * SEG_DIV[c_seg]);
    rem        = c_dvd - back_prod;
    d_next.seg = c_seg;
    d_next.quo = c_qest + Q_W'(rem >= dvsr);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= in_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_seg  <= in_data.seg;
      c_dvd  <= in_data.dvd;
      c_qest <= qest_next;
    end
    if (d_ready && c_valid) begin
      d_data <= d_next;
    end
  end

endmodule

@@ rtl/aqi_cat.sv @@
// ----------------------------------------------------------------------------
// aqi_cat: index, saturation and bracket
// Adds the segment's index base, clamps to 16 bits and looks up the
// quality bracket and its colour into the output register.
// ----------------------------------------------------------------------------
module aqi_cat (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aqi_pkg::aqi_quo_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aqi_pkg::aqi_res_t out_data
);
  import aqi_pkg::*;

  logic     e_valid;
  aqi_res_t e_data;

  logic [Q_W-1:0]   idx;
  logic             sat;
  logic [AQI_W-1:0] aqi;
  aqi_res_t         e_next;

  assign in_ready  = !e_valid || out_ready;
  assign out_valid = e_valid;
  assign out_data  = e_data;

  // Index, clamp, then the first bracket whose bound is not below it.
  always_comb begin
    idx = in_data.quo + Q_W'(SEG_BASE[in_data.seg]);
    sat = |idx[Q_W-1:AQI_W];
    aqi = sat ? {AQI_W{1'b1}} : idx[AQI_W-1:0];
    e_next.aqi_value = aqi;
    e_next.saturated = sat;
    e_next.category  = CAT_HAZARDOUS;
    e_next.colour    = '0;
    for (int i = BRACKETS - 1; i >= 0; i--) begin
      if (aqi <= AQI_W'(BRK_MAX[i])) begin
        e_next.category = CAT_W'(i);
        e_next.colour   = BRK_RGB[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (in_ready) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      e_data <= e_next;
    end
  end

endmodule

@@ rtl/pm25_to_aqi_with_category_unit.sv @@
// ----------------------------------------------------------------------------
// pm25_to_aqi_with_category_unit: PM2.5 reading to air quality index
// Piecewise linear index with half-up rounding, 16-bit saturation,
// quality bracket and bracket colour, in a five-stage pipeline.
//
//   Channel | Direction | tdata fields, low bit first
//   s_*     | in        | pm25_reading[15:0]
//   m_*     | out       | aqi_value[15:0], category[18:16], colour[42:19],
//           |           | saturated[43], zero[47:44]
//
// One item per cycle is accepted unless stalled; each passes through the
// segment, dividend, reciprocal multiply, remainder correction and bracket
// lookup stages to m_tvalid. Each stage holds its item while the next is
// full, so a stall on m_tready fills empty stages before s_tready drops.
// Synchronous reset empties the pipeline; no payload is cleared.
// ----------------------------------------------------------------------------
module pm25_to_aqi_with_category_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pm25_reading[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // aqi_value, category, colour, saturated, pad
);
  import aqi_pkg::*;

  logic     seg_valid;
  logic     seg_ready;
  aqi_dvd_t seg_data;
  logic     div_valid;
  logic     div_ready;
  aqi_quo_t div_data;
  aqi_res_t res;

  // Segment choice and dividend.
  aqi_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .rd        (s_tdata),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_data  (seg_data)
  );

  // Constant division.
  aqi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .in_data   (seg_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // Index, saturation and bracket.
  aqi_cat u_cat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {4'b0000, res.saturated, res.colour, res.category, res.aqi_value};

  // A clamped index always lands in the hazardous bracket with no colour.
  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[43] |->
      m_tdata[15:0] == 16'hFFFF && m_tdata[18:16] == CAT_HAZARDOUS &&
      m_tdata[42:19] == 24'h000000)
    else $error("saturated item without clamped index, bracket or colour");

  // Colour is zero exactly when the index is above 999.
  a_colour_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[42:19] == 24'h000000) == (m_tdata[15:0] > 16'd999)))
    else $error("colour does not match index range");

  // The bracket code never exceeds the hazardous bracket.
  a_cat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:16] <= CAT_HAZARDOUS)
    else $error("bracket code out of range");

  // Reset empties the output stage.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

@@ verif/pm25_to_aqi_with_category_unit_tb.sv @@
// ----------------------------------------------------------------------------
// pm25_to_aqi_with_category_unit_tb: self-checking bench of the PM2.5 to AQI unit
// Sends PM2.5 readings on the input stream and checks every index item on the
// output stream against a hand-worked result or a local piecewise-linear
// model of the index, its bracket and colour. A short table of edge readings
// runs first. Random readings follow, with random idle cycles on both sides,
// a long output hold-off and a full drain in the middle.
// ----------------------------------------------------------------------------
module pm25_to_aqi_with_category_unit_tb;

  // Quality bracket codes as they appear in the category field.
  typedef enum logic [2:0] {
    BRACKET_GOOD           = 3'd0,
    BRACKET_MODERATE       = 3'd1,
    BRACKET_SENSITIVE      = 3'd2,
    BRACKET_UNHEALTHY      = 3'd3,
    BRACKET_VERY_UNHEALTHY = 3'd4,
    BRACKET_HAZARDOUS      = 3'd5
  } bracket_e;

  // Bracket colours.
  localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
  localparam logic [23:0] RGB_YELLOW = 24'hFFFF00;
  localparam logic [23:0] RGB_ORANGE = 24'hFFA500;
  localparam logic [23:0] RGB_RED    = 24'hFF0000;
  localparam logic [23:0] RGB_PURPLE = 24'h9400D3;
  localparam logic [23:0] RGB_NONE   = 24'h000000;

  localparam int RANDOM_READINGS = 1400;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 12;

  // One reading with the index item it should produce.
  typedef struct {
    logic [15:0]       reading;
    aqi_pkg::aqi_res_t res;
  } aqi_expect_t;

  // One row of the directed table; typed rows carry a hand-worked result.
  typedef struct {
    logic [15:0]       reading;
    bit                typed;
    aqi_pkg::aqi_res_t want;
  } edge_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  aqi_expect_t pending_aqi[$];
  edge_row_t   edge_rows[$];
  int          mismatch_count = 0;
  int          readings_sent = 0;
  int          results_checked = 0;
  int          saturated_seen = 0;
  int          bracket_hits[6] = '{0, 0, 0, 0, 0, 0};
  logic        gaps_on = 1'b1;
  logic        hold_request = 1'b0;

  pm25_to_aqi_with_category_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // pm25_reading[15:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)     // aqi_value, category, colour, saturated, zero pad
  );

  // Free-running clock.
  always #10 clk = ~clk;

  // Interpolated index of one reading, with bracket and colour.
  function automatic aqi_pkg::aqi_res_t pm25_to_aqi(input logic [15:0] reading);
    longint unsigned   r10, lo, span, ispan, base, num, idx;
    aqi_pkg::aqi_res_t res;
    r10 = 64'(reading) * 64'd10;
    // The last segment whose lower bound is not above the reading wins.
    if (r10 >= 64'd2505) begin
      lo = 2505; span = 2499; ispan = 999; base = 301;
    end else if (r10 >= 64'd1505) begin
      lo = 1505; span = 999; ispan = 99; base = 201;
    end else if (r10 >= 64'd655) begin
      lo = 655; span = 849; ispan = 49; base = 151;
    end else if (r10 >= 64'd405) begin
      lo = 405; span = 249; ispan = 49; base = 101;
    end else if (r10 >= 64'd155) begin
      lo = 155; span = 249; ispan = 49; base = 51;
    end else begin
      lo = 0; span = 154; ispan = 50; base = 0;
    end
    // Half-up rounding of num / span, done in integers.
    num = (r10 - lo) * ispan;
    idx = (2 * num + span) / (2 * span) + base;
    res.saturated = (idx > 64'd65535);
    res.aqi_value = res.saturated ? 16'hFFFF : idx[15:0];
    // Bracket and colour come from the clamped index.
    if (res.aqi_value <= 16'd50) begin
      res.category = BRACKET_GOOD;           res.colour = RGB_GREEN;
    end else if (res.aqi_value <= 16'd100) begin
      res.category = BRACKET_MODERATE;       res.colour = RGB_YELLOW;
    end else if (res.aqi_value <= 16'd150) begin
      res.category = BRACKET_SENSITIVE;      res.colour = RGB_ORANGE;
    end else if (res.aqi_value <= 16'd200) begin
      res.category = BRACKET_UNHEALTHY;      res.colour = RGB_RED;
    end else if (res.aqi_value <= 16'd300) begin
      res.category = BRACKET_VERY_UNHEALTHY; res.colour = RGB_PURPLE;
    end else if (res.aqi_value <= 16'd999) begin
      res.category = BRACKET_HAZARDOUS;      res.colour = RGB_PURPLE;
    end else begin
      res.category = BRACKET_HAZARDOUS;      res.colour = RGB_NONE;
    end
    return res;
  endfunction

  // Directed row with a result worked out by hand.
  function automatic edge_row_t typed_row(input logic [15:0] reading,
                                          input logic [15:0] aqi, input bracket_e cat,
                                          input logic [23:0] rgb, input logic sat);
    edge_row_t row;
    row.reading = reading;
    row.typed = 1'b1;
    row.want.aqi_value = aqi;
    row.want.category = cat;
    row.want.colour = rgb;
    row.want.saturated = sat;
    return row;
  endfunction

  // Directed row that is checked against the model.
  function automatic edge_row_t modeled_row(input logic [15:0] reading);
    edge_row_t row;
    row.reading = reading;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [15:0] reading,
                                 input longint unsigned want, input longint unsigned got);
    $display("MISMATCH %s: reading %0d expected 0x%0h got 0x%0h at %0t",
             what, reading, want, got, $realtime);
    mismatch_count++;
  endtask

  // Offer one reading, wait for it to be taken and record its expected item.
  task automatic send_reading(input logic [15:0] reading, input bit typed,
                              input aqi_pkg::aqi_res_t want);
    aqi_expect_t item;
    while (gaps_on && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= reading;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    item.reading = reading;
    item.res = typed ? want : pm25_to_aqi(reading);
    pending_aqi.push_back(item);
    readings_sent++;
  endtask

  // Random reading, weighted toward the breakpoints and the saturation edge.
  function automatic logic [15:0] random_reading();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return 16'($urandom_range(600));
    else if (pick < 75) return 16'($urandom_range(20000, 600));
    else if (pick < 85) return 16'($urandom_range(17000, 16000));
    else return 16'($urandom());
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= !(gaps_on && $urandom_range(99) < 7);
        @(posedge clk);
      end
    end
  end

  // Check each output item against the oldest expectation.
  always @(posedge clk) begin
    aqi_expect_t       exp_item;
    aqi_pkg::aqi_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = aqi_pkg::aqi_res_t'(m_tdata[43:0]);
      if (pending_aqi.size() == 0) begin
        report_mismatch("unexpected item", 16'd0, 0, m_tdata);
      end else begin
        exp_item = pending_aqi.pop_front();
        results_checked++;
        if (got.aqi_value !== exp_item.res.aqi_value)
          report_mismatch("aqi_value", exp_item.reading, exp_item.res.aqi_value,
                          got.aqi_value);
        if (got.category !== exp_item.res.category)
          report_mismatch("category", exp_item.reading, exp_item.res.category,
                          got.category);
        if (got.colour !== exp_item.res.colour)
          report_mismatch("colour", exp_item.reading, exp_item.res.colour, got.colour);
        if (got.saturated !== exp_item.res.saturated)
          report_mismatch("saturated", exp_item.reading, exp_item.res.saturated,
                          got.saturated);
        if (m_tdata[47:44] !== 4'd0)
          report_mismatch("pad bits", exp_item.reading, 0, m_tdata[47:44]);
        if (exp_item.res.saturated) saturated_seen++;
        bracket_hits[exp_item.res.category]++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int                i;
    logic [15:0]       rd;
    aqi_pkg::aqi_res_t none;
    none = '0;

    // Edge readings: segment boundaries, bracket boundaries, extremes.
    edge_rows.push_back(typed_row(16'd0,     16'd0,     BRACKET_GOOD, RGB_GREEN, 1'b0));
    edge_rows.push_back(typed_row(16'd15,    16'd49,    BRACKET_GOOD, RGB_GREEN, 1'b0));
    edge_rows.push_back(typed_row(16'd16,    16'd52,    BRACKET_MODERATE, RGB_YELLOW, 1'b0));
    edge_rows.push_back(typed_row(16'd40,    16'd99,    BRACKET_MODERATE, RGB_YELLOW, 1'b0));
    edge_rows.push_back(typed_row(16'd41,    16'd102,   BRACKET_SENSITIVE, RGB_ORANGE, 1'b0));
    edge_rows.push_back(typed_row(16'd65,    16'd149,   BRACKET_SENSITIVE, RGB_ORANGE, 1'b0));
    edge_rows.push_back(typed_row(16'd66,    16'd151,   BRACKET_UNHEALTHY, RGB_RED, 1'b0));
    edge_rows.push_back(typed_row(16'd150,   16'd200,   BRACKET_UNHEALTHY, RGB_RED, 1'b0));
    edge_rows.push_back(typed_row(16'd151,   16'd201,   BRACKET_VERY_UNHEALTHY, RGB_PURPLE,
                                  1'b0));
    edge_rows.push_back(typed_row(16'd250,   16'd300,   BRACKET_VERY_UNHEALTHY, RGB_PURPLE,
                                  1'b0));
    edge_rows.push_back(typed_row(16'd251,   16'd303,   BRACKET_HAZARDOUS, RGB_PURPLE, 1'b0));
    edge_rows.push_back(typed_row(16'hFFFF,  16'hFFFF,  BRACKET_HAZARDOUS, RGB_NONE, 1'b1));
    edge_rows.push_back(modeled_row(16'd1));
    edge_rows.push_back(modeled_row(16'd424));
    edge_rows.push_back(modeled_row(16'd425));
    edge_rows.push_back(modeled_row(16'd426));
    edge_rows.push_back(modeled_row(16'd2000));
    edge_rows.push_back(modeled_row(16'd16568));
    edge_rows.push_back(modeled_row(16'd16569));
    edge_rows.push_back(modeled_row(16'd16570));
    edge_rows.push_back(modeled_row(16'h5555));
    edge_rows.push_back(modeled_row(16'hAAAA));
    edge_rows.push_back(modeled_row(16'h00FF));
    edge_rows.push_back(modeled_row(16'hFF00));

    // Hold reset, then release it.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (i = 0; i < edge_rows.size(); i++)
      send_reading(edge_rows[i].reading, edge_rows[i].typed, edge_rows[i].want);

    // Random readings with the pressure points spread through the run.
    for (i = 0; i < RANDOM_READINGS; i++) begin
      if (i == 300) hold_request <= 1'b1;
      if (i == 700) begin
        // Let the pipeline run dry before going on.
        s_tvalid <= 1'b0;
        while (pending_aqi.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (i == 900) gaps_on <= 1'b0;
      if (i == 1100) gaps_on <= 1'b1;
      rd = random_reading();
      send_reading(rd, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    // Drain, then idle so that any stray item shows up.
    while (pending_aqi.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_aqi.size() != 0)
      report_mismatch("missing item", pending_aqi[0].reading, pending_aqi.size(), 0);

    $display("Sent %0d readings, checked %0d index items, %0d of them saturated.",
             readings_sent, results_checked, saturated_seen);
    $display("Items per bracket, good to hazardous: %0d %0d %0d %0d %0d %0d.",
             bracket_hits[0], bracket_hits[1], bracket_hits[2],
             bracket_hits[3], bracket_hits[4], bracket_hits[5]);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d items still expected.", pending_aqi.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ pm25_to_aqi_with_category_unit.f @@
rtl/aqi_pkg.sv
rtl/aqi_seg.sv
rtl/aqi_div.sv
rtl/aqi_cat.sv
rtl/pm25_to_aqi_with_category_unit.sv
verif/pm25_to_aqi_with_category_unit_tb.sv
